// ===== hw/rtl/adaptive_trim_learner_top_defines.svh =====
// Assertion macros for the trim learner.
`ifndef ADAPTIVE_TRIM_LEARNER_TOP_DEFINES_SVH
`define ADAPTIVE_TRIM_LEARNER_TOP_DEFINES_SVH

// Same-cycle implication on clk, idle under reset.
`define ATL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, idle under reset.
`define ATL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/atl_pkg.sv =====
`timescale 1ns / 1ps
package atl_pkg;

	localparam int SEQ_WIDTH_DEF = 32;
	localparam int FEB_DEF       = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 20;
	localparam int DVS_W         = 21;

	localparam logic [19:0]        FILTER_TAU_RST   = 20'd10000;
	localparam logic [14:0]        REJECT_RATE_RST  = 15'd0;
	localparam logic signed [15:0] MIN_DRIVE_RST    = 16'sd0;
	localparam logic [14:0]        DEAD_ZONE_RST    = 15'd0;
	localparam logic [15:0]        STEP_RATE_RST    = 16'd0;
	localparam logic signed [15:0] TRIM_FLOOR_RST   = -16'sd32768;
	localparam logic signed [15:0] TRIM_CEILING_RST = 16'sd32767;
	localparam logic [15:0]        MAX_GAP_RST      = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_TAU   = 3'd0,
		REG_REJECT_RATE  = 3'd1,
		REG_MIN_DRIVE    = 3'd2,
		REG_DEAD_ZONE    = 3'd3,
		REG_STEP_RATE    = 3'd4,
		REG_TRIM_FLOOR   = 3'd5,
		REG_TRIM_CEILING = 3'd6,
		REG_MAX_GAP      = 3'd7
	} atl_reg_t;

	typedef struct packed {
		logic [19:0]        filter_tau;
		logic [14:0]        reject_rate;
		logic signed [15:0] min_drive;
		logic [14:0]        dead_zone;
		logic [15:0]        step_rate;
		logic signed [15:0] trim_floor;
		logic signed [15:0] trim_ceiling;
		logic [15:0]        max_gap;
	} atl_cfg_t;

endpackage

// ===== hw/rtl/adaptive_trim_learner_top.sv =====
// Path: a dropped, rejected, resync or restart word goes from accept through CHECK, SPLIT and
// OUT, which loads the output register; a filtered sample passes CHECK, MUL, DLOAD, DIV, GATE,
// TRIM only if the trim steps, then SPLIT and OUT. The next word is taken the cycle after the
// output load, one word at a time; the yaw filter divider sets the long case; out_stall holds OUT.
// Reset (arst_n, async, low): trim, filter, estimate, fault, last sequence cleared;
// registers return to their defaults. No clearing pass.
`timescale 1ns / 1ps
`include "adaptive_trim_learner_top_defines.svh"
module adaptive_trim_learner_top import atl_pkg::*; #(
	parameter int SEQ_WIDTH         = SEQ_WIDTH_DEF,
	parameter int FILTER_EXTRA_BITS = FEB_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [31:0]           sample_seq,
	input  logic [15:0]           interval,
	input  logic signed [15:0]    yaw_rate,
	input  logic signed [15:0]    drive,
	input  logic                  turning,
	input  logic                  sensor_ok,
	input  logic signed [15:0]    trim_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  ok,
	output logic signed [15:0]    trim,
	output logic                  fault,
	output logic signed [15:0]    split
);

	localparam int FY_W  = 16 + FILTER_EXTRA_BITS;
	localparam int DF_W  = FY_W + 1;
	localparam int MB_W  = 17;
	localparam int P_W   = DF_W + MB_W;
	localparam int PM_W  = FY_W + 16;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_MUL   = 9'b000000100,
		ST_DLOAD = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_GATE  = 9'b000100000,
		ST_TRIM  = 9'b001000000,
		ST_SPLIT = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	atl_cfg_t cfg;

	atl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	state_t state_q;

	// latched input word
	logic                 op_q;
	logic [SEQ_WIDTH-1:0] seq_q;
	logic [15:0]          dt_q;
	logic signed [15:0]   yaw_q;
	logic signed [15:0]   drive_q;
	logic                 turn_q;
	logic                 sok_q;
	logic signed [15:0]   tval_q;

	// learner state
	logic signed [15:0]   trim_q;
	logic signed [FY_W-1:0] filt_q;
	logic                 est_q;
	logic                 fault_q;
	logic [SEQ_WIDTH-1:0] prev_seq_q;
	logic                 ok_q;
	logic                 neg_q;

	// shared multiplier
	logic signed [DF_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  prod_q;

	// output register
	logic                 out_valid_q;
	logic                 ok_o_q;
	logic signed [15:0]   trim_o_q;
	logic                 fault_o_q;
	logic signed [15:0]   split_o_q;

	logic signed [FY_W-1:0] target;
	logic signed [DF_W-1:0] diff;
	logic signed [16:0]     yaw_ext;
	logic [16:0]            yaw_mag;
	logic                   reject;
	logic                   resync;
	logic                   in_range;
	logic [P_W-1:0]         prod_abs;
	logic [PM_W-1:0]        quo;
	logic [DVS_W-1:0]       divisor;
	logic                   div_start;
	logic                   div_done;
	logic signed [FY_W:0]   q_ext;
	logic signed [FY_W:0]   filt_nx;
	logic signed [FY_W:0]   filt_ext;
	logic [FY_W:0]          filt_mag;
	logic [FY_W:0]          dz_scaled;
	logic                   quiet;
	logic signed [17:0]     step_ext;
	logic signed [17:0]     trim_nx;
	logic                   at_floor;
	logic                   at_ceil;
	logic signed [15:0]     trim_new;
	logic signed [P_W-1:0]  prod_sh;
	logic signed [15:0]     split_nx;
	logic                   out_free;

	assign target   = FY_W'(yaw_q) <<< FILTER_EXTRA_BITS;
	assign diff     = DF_W'(target) - DF_W'(filt_q);
	assign yaw_ext  = 17'(yaw_q);
	assign yaw_mag  = yaw_ext[16] ? 17'(-yaw_ext) : 17'(yaw_ext);
	assign reject   = (cfg.reject_rate != '0) && (yaw_mag > 17'(cfg.reject_rate));
	assign resync   = !est_q || (dt_q == '0) || (dt_q > cfg.max_gap);
	assign in_range = (tval_q >= $signed(cfg.trim_floor)) &&
	                  (tval_q <= $signed(cfg.trim_ceiling));

	always_comb begin
		case (state_q)
			ST_MUL: begin
				mul_a = diff;
				mul_b = $signed({1'b0, dt_q});
			end
			ST_GATE: begin
				mul_a = DF_W'($signed({1'b0, cfg.step_rate}));
				mul_b = $signed({1'b0, dt_q});
			end
			default: begin
				mul_a = DF_W'(trim_q);
				mul_b = MB_W'(drive_q);
			end
		endcase
	end

	assign prod_abs  = prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);
	assign divisor   = DVS_W'(cfg.filter_tau) + DVS_W'(dt_q);
	assign div_start = (state_q == ST_DLOAD);

	atl_div #(
		.N_W (PM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_abs[PM_W-1:0]),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// quotient magnitude stays below 2^FY_W
	assign q_ext     = $signed({1'b0, quo[FY_W-1:0]});
	assign filt_nx   = (FY_W+1)'(filt_q) + (neg_q ? -q_ext : q_ext);
	assign filt_ext  = (FY_W+1)'(filt_q);
	assign filt_mag  = filt_ext[FY_W] ? (FY_W+1)'(-filt_ext) : (FY_W+1)'(filt_ext);
	assign dz_scaled = (FY_W+1)'(cfg.dead_zone) << FILTER_EXTRA_BITS;
	assign quiet     = fault_q || (drive_q < $signed(cfg.min_drive)) ||
	                   (filt_mag <= dz_scaled);

	assign step_ext = $signed({2'b00, prod_q[31:16]});
	assign trim_nx  = filt_q[FY_W-1] ? 18'(trim_q) + step_ext : 18'(trim_q) - step_ext;
	assign at_floor = (trim_nx <= 18'($signed(cfg.trim_floor)));
	assign at_ceil  = (trim_nx >= 18'($signed(cfg.trim_ceiling)));
	assign trim_new = at_floor ? $signed(cfg.trim_floor) :
	                  at_ceil  ? $signed(cfg.trim_ceiling) : trim_nx[15:0];

	// floor of trim*drive / 2^14, saturated; zero when drive is not positive
	assign prod_sh = prod_q >>> 14;
	always_comb begin
		if (drive_q <= 16'sd0)
			split_nx = 16'sd0;
		else if (prod_sh > P_W'(32767))
			split_nx = 16'sd32767;
		else if (prod_sh < -P_W'(32768))
			split_nx = -16'sd32768;
		else
			split_nx = prod_sh[15:0];
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			trim_q      <= '0;
			filt_q      <= '0;
			est_q       <= 1'b0;
			fault_q     <= 1'b0;
			prev_seq_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_SPLIT;
					if (op_q) begin
						if (in_range) begin
							trim_q  <= tval_q;
							est_q   <= 1'b0;
							fault_q <= 1'b0;
							filt_q  <= '0;
						end
					end else if (seq_q != prev_seq_q) begin
						prev_seq_q <= seq_q;
						if (sok_q) begin
							if (turn_q || reject) begin
								est_q <= 1'b0;
							end else if (resync) begin
								filt_q <= target;
								est_q  <= 1'b1;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_MUL:   state_q <= ST_DLOAD;
				ST_DLOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						filt_q  <= filt_nx[FY_W-1:0];
						state_q <= ST_GATE;
					end
				end
				ST_GATE: state_q <= quiet ? ST_SPLIT : ST_TRIM;
				ST_TRIM: begin
					trim_q <= trim_new;
					if (at_floor || at_ceil)
						fault_q <= 1'b1;
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && in_valid) begin
			op_q    <= opcode;
			seq_q   <= sample_seq[SEQ_WIDTH-1:0];
			dt_q    <= interval;
			yaw_q   <= yaw_rate;
			drive_q <= drive;
			turn_q  <= turning;
			sok_q   <= sensor_ok;
			tval_q  <= trim_value;
		end
		if (state_q == ST_CHECK)
			ok_q <= op_q && in_range;
		if (state_q == ST_TRIM)
			ok_q <= (trim_new != trim_q);
		if (state_q == ST_DLOAD)
			neg_q <= prod_q[P_W-1];
		if (state_q == ST_OUT && out_free) begin
			ok_o_q    <= ok_q;
			trim_o_q  <= trim_q;
			fault_o_q <= fault_q;
			split_o_q <= split_nx;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_o_q;
	assign trim      = trim_o_q;
	assign fault     = fault_o_q;
	assign split     = split_o_q;

	`ATL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word accepted but block not busy")
	`ATL_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV, "divider finished outside divide phase")
	`ATL_ASSERT_NOW(a_fault_from_trim, $rose(fault_q), $past(state_q == ST_TRIM), "fault latched outside trim update")

endmodule

// ===== hw/rtl/atl_cfg.sv =====
`timescale 1ns / 1ps
module atl_cfg import atl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output atl_cfg_t              regs
);

	atl_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.filter_tau   <= FILTER_TAU_RST;
			regs_q.reject_rate  <= REJECT_RATE_RST;
			regs_q.min_drive    <= MIN_DRIVE_RST;
			regs_q.dead_zone    <= DEAD_ZONE_RST;
			regs_q.step_rate    <= STEP_RATE_RST;
			regs_q.trim_floor   <= TRIM_FLOOR_RST;
			regs_q.trim_ceiling <= TRIM_CEILING_RST;
			regs_q.max_gap      <= MAX_GAP_RST;
		end else if (cfg_write) begin
			case (atl_reg_t'(cfg_index))
				REG_FILTER_TAU:   regs_q.filter_tau   <= cfg_data[19:0];
				REG_REJECT_RATE:  regs_q.reject_rate  <= cfg_data[14:0];
				REG_MIN_DRIVE:    regs_q.min_drive    <= $signed(cfg_data[15:0]);
				REG_DEAD_ZONE:    regs_q.dead_zone    <= cfg_data[14:0];
				REG_STEP_RATE:    regs_q.step_rate    <= cfg_data[15:0];
				REG_TRIM_FLOOR:   regs_q.trim_floor   <= $signed(cfg_data[15:0]);
				REG_TRIM_CEILING: regs_q.trim_ceiling <= $signed(cfg_data[15:0]);
				REG_MAX_GAP:      regs_q.max_gap      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== hw/rtl/atl_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, two quotient bits per cycle.
module atl_div import atl_pkg::*; #(
	parameter int N_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [N_W-1:0]   dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [N_W-1:0]   quotient
);

	localparam int ITER  = (N_W + 1) / 2;
	localparam int NP_W  = 2 * ITER;
	localparam int CNT_W = $clog2(ITER);

	logic [NP_W-1:0]  num_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   r1;
	logic [DVS_W:0]   r2;
	logic [DVS_W-1:0] rem1;
	logic [DVS_W-1:0] rem2;
	logic             q1;
	logic             q2;

	always_comb begin
		r1 = {rem_q, num_q[NP_W-1]};
		q1 = (r1 >= {1'b0, dvs_q});
		rem1 = q1 ? DVS_W'(r1 - {1'b0, dvs_q}) : r1[DVS_W-1:0];
		r2 = {rem1, num_q[NP_W-2]};
		q2 = (r2 >= {1'b0, dvs_q});
		rem2 = q2 ? DVS_W'(r2 - {1'b0, dvs_q}) : r2[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NP_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NP_W-3:0], q1, q2};
			rem_q <= rem2;
		end
	end

	assign done     = done_q;
	assign quotient = num_q[N_W-1:0];

endmodule
